/* design/priority_ready_queue_macros.svh */
// Assertion macros for the priority ready queue.
`ifndef PRIORITY_READY_QUEUE_MACROS_SVH
`define PRIORITY_READY_QUEUE_MACROS_SVH
`ifndef SYNTHESIS
`define PRQ_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define PRQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define PRQ_ASSERT_IMP(label, clk, rst, ante, cons)
`define PRQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* design/prq_pkg.sv */
// Shared types and constants of the priority ready queue.
`default_nettype none
package prq_pkg;
   localparam int NUM_TASKS  = 64;
   localparam int NUM_LEVELS = 32;
   localparam int TASK_W     = $clog2(NUM_TASKS);
   localparam int LEVEL_W    = $clog2(NUM_LEVELS);
   localparam int COUNT_W    = $clog2(NUM_TASKS + 1);

   localparam logic [1:0] REQ_PUSH   = 2'd0;
   localparam logic [1:0] REQ_REMOVE = 2'd1;
   localparam logic [1:0] REQ_YIELD  = 2'd2;

   // Controller to datapath
   typedef struct packed {
      logic load;     // capture request, read task level and links
      logic fetch;    // decode and read head/tail of the working level
      logic execute;  // perform update
      logic finish;   // latch result
   } prq_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic busy;     // request is carried out (a yield only by the head)
   } prq_status_type;
endpackage
`default_nettype wire

/* design/prq_datapath.sv */
// Datapath of the priority ready queue: link memories, bitmap, count.
`default_nettype none
module prq_datapath (
   input  wire                        clock,
   input  wire                        reset,
   input  wire prq_pkg::prq_cmd_type  cmd,
   output prq_pkg::prq_status_type    status,
   input  wire [1:0]                  req_type,
   input  wire [prq_pkg::TASK_W-1:0]  task_id,
   input  wire [4:0]                  priority_req,
   output logic [prq_pkg::TASK_W-1:0] res_next_task,
   output logic                       res_next_valid,
   output logic [prq_pkg::LEVEL_W-1:0] res_top_priority,
   output logic [prq_pkg::COUNT_W-1:0] res_ready_count,
   output logic                       res_request_error
);
   localparam int TW = prq_pkg::TASK_W;
   localparam int LW = prq_pkg::LEVEL_W;
   localparam int NL = prq_pkg::NUM_LEVELS;
   localparam int NT = prq_pkg::NUM_TASKS;

   // Per-level and per-task stores
   logic [TW-1:0] head_mem [NL];
   logic [TW-1:0] tail_mem [NL];
   logic [TW-1:0] next_mem [NT];
   logic [TW-1:0] prev_mem [NT];
   logic [LW-1:0] lvl_mem  [NT];

   logic [NL-1:0] bitmap_ff, bitmap_in;
   logic [NT-1:0] queued_ff, queued_in;
   logic [prq_pkg::COUNT_W-1:0] count_ff, count_in;

   logic [1:0]    req_ff;
   logic [TW-1:0] t_ff;
   logic [4:0]    pri_ff;
   logic [LW-1:0] lvl_rd_ff; // level the task was pushed on
   logic [LW-1:0] lv_ff;     // working level
   logic          err_ff;
   logic          act_ff;    // operation does something
   logic [TW-1:0] head_rd_ff, tail_rd_ff, nxt_rd_ff, prv_rd_ff;

   // Top-level search over the bitmap
   logic [LW-1:0] top_lv;
   always_comb begin
      top_lv = LW'(NL - 1);
      for (int i = NL - 1; i >= 0; i--) begin
         if (bitmap_ff[i]) begin
            top_lv = LW'(i);
         end
      end
   end

   // Request decode at fetch, from the captured request
   logic [LW-1:0] push_lv, sel_lv;
   logic          ld_err, ld_act;
   always_comb begin
      push_lv = (32'(pri_ff) >= NL) ? LW'(NL - 1) : LW'(pri_ff);
      sel_lv  = LW'(0);
      ld_err  = 1'b0;
      ld_act  = 1'b0;
      unique case (req_ff)
         prq_pkg::REQ_PUSH: begin
            sel_lv = push_lv;
            ld_err = queued_ff[t_ff];
            ld_act = !queued_ff[t_ff];
         end
         prq_pkg::REQ_REMOVE: begin
            sel_lv = lvl_rd_ff;
            ld_err = !queued_ff[t_ff];
            ld_act = queued_ff[t_ff];
         end
         prq_pkg::REQ_YIELD: begin
            sel_lv = top_lv;
            ld_act = (bitmap_ff != '0) && (head_mem[top_lv] == t_ff);
         end
         default: begin
            sel_lv = LW'(0);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
      end else if (cmd.fetch) begin
         act_ff <= ld_act;
      end
   end

   // Request capture
   always_ff @(posedge clock) begin
      if (reset) begin
         req_ff <= prq_pkg::REQ_PUSH;
         t_ff   <= '0;
         pri_ff <= '0;
      end else if (cmd.load) begin
         req_ff <= req_type;
         t_ff   <= task_id;
         pri_ff <= priority_req;
      end
   end

   // Registered reads of the stores
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         lvl_rd_ff <= lvl_mem[task_id];
         nxt_rd_ff <= next_mem[task_id];
         prv_rd_ff <= prev_mem[task_id];
      end
      if (cmd.fetch) begin
         lv_ff      <= sel_lv;
         err_ff     <= ld_err;
         head_rd_ff <= head_mem[sel_lv];
         tail_rd_ff <= tail_mem[sel_lv];
      end
   end

   // Update decode
   logic lvl_bit;
   logic is_head, is_tail;
   assign lvl_bit = bitmap_ff[lv_ff];
   assign is_head = head_rd_ff == t_ff;
   assign is_tail = tail_rd_ff == t_ff;

   always_comb begin
      bitmap_in = bitmap_ff;
      queued_in = queued_ff;
      count_in  = count_ff;
      if (cmd.execute && act_ff) begin
         priority case (req_ff)
            prq_pkg::REQ_PUSH: begin
               bitmap_in[lv_ff] = 1'b1;
               queued_in[t_ff]  = 1'b1;
               count_in         = count_ff + 1'b1;
            end
            prq_pkg::REQ_REMOVE: begin
               if (is_head && is_tail) begin
                  bitmap_in[lv_ff] = 1'b0;
               end
               queued_in[t_ff] = 1'b0;
               count_in        = count_ff - 1'b1;
            end
            default: begin
               bitmap_in = bitmap_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bitmap_ff <= '0;
         queued_ff <= '0;
         count_ff  <= '0;
      end else begin
         bitmap_ff <= bitmap_in;
         queued_ff <= queued_in;
         count_ff  <= count_in;
      end
   end

   // Link memory writes
   always_ff @(posedge clock) begin
      if (cmd.execute && act_ff) begin
         unique case (req_ff)
            prq_pkg::REQ_PUSH: begin
               lvl_mem[t_ff]  <= lv_ff;
               tail_mem[lv_ff] <= t_ff;
               if (!lvl_bit) begin
                  head_mem[lv_ff] <= t_ff;
               end else begin
                  next_mem[tail_rd_ff] <= t_ff;
                  prev_mem[t_ff]       <= tail_rd_ff;
               end
            end
            prq_pkg::REQ_REMOVE: begin
               if (is_head && is_tail) begin
                  head_mem[lv_ff] <= head_rd_ff;
               end else if (is_head) begin
                  head_mem[lv_ff] <= nxt_rd_ff;
               end else if (is_tail) begin
                  tail_mem[lv_ff] <= prv_rd_ff;
               end else begin
                  next_mem[prv_rd_ff] <= nxt_rd_ff;
                  prev_mem[nxt_rd_ff] <= prv_rd_ff;
               end
            end
            prq_pkg::REQ_YIELD: begin
               // head rotates to tail; single entry stays as it is
               if (!is_tail) begin
                  head_mem[lv_ff]      <= nxt_rd_ff;
                  tail_mem[lv_ff]      <= t_ff;
                  next_mem[tail_rd_ff] <= t_ff;
                  prev_mem[t_ff]       <= tail_rd_ff;
               end
            end
            default: begin
               lvl_mem[t_ff] <= lvl_mem[t_ff];
            end
         endcase
      end
   end

   // Result capture after the update
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         res_next_valid    <= bitmap_ff != '0;
         res_next_task     <= (bitmap_ff != '0) ? head_mem[top_lv] : '0;
         res_top_priority  <= (bitmap_ff != '0) ? top_lv : '0;
         res_ready_count   <= count_ff;
         res_request_error <= err_ff;
      end
   end

   assign status.busy = act_ff;
endmodule
`default_nettype wire

/* design/prq_controller.sv */
// Sequencing controller of the priority ready queue.
`default_nettype none
module prq_controller (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output prq_pkg::prq_cmd_type      cmd,
   input  wire prq_pkg::prq_status_type status
);
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_FETCH = 2'd1;
   localparam logic [1:0] ST_EXEC  = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       out_ff, out_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = out_ff;

   always_comb begin
      state_in    = state_ff;
      out_in      = out_ff && rsp_stall;
      cmd.load    = 1'b0;
      cmd.fetch   = 1'b0;
      cmd.execute = 1'b0;
      cmd.finish  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_EXEC;
         end
         ST_EXEC: begin
            // only requests that change the queue write the stores
            cmd.execute = status.busy;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            // wait for output register to free
            if (!out_ff || !rsp_stall) begin
               cmd.finish = 1'b1;
               out_in     = 1'b1;
               state_in   = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_ff   <= out_in;
      end
   end
endmodule
`default_nettype wire

/* design/priority_ready_queue.sv */
// Priority ready queue for a task scheduler.
// Input channel req_*: one request (push, remove or yield) per transfer.
// Result channel rsp_*: one status transfer per request: head of the top
// non-empty level, its level, ready count and an error flag.
// Each request runs through load (capture, read the task's level and
// links), fetch (decode, read head and tail of the level), execute (write
// the link stores), finish (compute top level into the output register).
// One request is in flight at a time, so a new request is taken only
// after the last one has passed its finish step.
// rsp_valid rises when the finish step fills the output register.
// Reset clears the level bitmap, queued flags and count: the queue is empty.
// Link stores are not cleared; only links of queued tasks are followed.
// If the receiver stalls, the result holds in its output register; the
// next request may run meanwhile and waits in its finish step until the
// output register is taken.
`default_nettype none
`include "priority_ready_queue_macros.svh"
module priority_ready_queue (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_stall,
   input  wire [1:0]                  req_type,
   input  wire [5:0]                  req_task_id,
   input  wire [4:0]                  req_priority_req,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output logic [5:0]                 rsp_next_task,
   output logic                       rsp_next_valid,
   output logic [4:0]                 rsp_top_priority,
   output logic [6:0]                 rsp_ready_count,
   output logic                       rsp_request_error
);
   prq_pkg::prq_cmd_type    cmd;
   prq_pkg::prq_status_type status;

   prq_controller u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .cmd, .status
   );

   prq_datapath u_dp (
      .clock, .reset, .cmd, .status,
      .req_type,
      .task_id           (req_task_id),
      .priority_req      (req_priority_req),
      .res_next_task     (rsp_next_task),
      .res_next_valid    (rsp_next_valid),
      .res_top_priority  (rsp_top_priority),
      .res_ready_count   (rsp_ready_count),
      .res_request_error (rsp_request_error)
   );

   // empty queue reports level and count as zero
   logic empty_zero;
   assign empty_zero = (rsp_top_priority == 5'd0) && (rsp_ready_count == 7'd0);

   `PRQ_ASSERT_NEXT(a_stall_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `PRQ_ASSERT_IMP(a_count_range, clock, reset, rsp_valid, rsp_ready_count <= 7'd64)
   `PRQ_ASSERT_IMP(a_empty_zero, clock, reset, rsp_valid && !rsp_next_valid, empty_zero)
endmodule
`default_nettype wire

/* tb/tb_priority_ready_queue.sv */
// Self-checking testbench for the priority ready queue.
`default_nettype none
module tb_priority_ready_queue;
   timeunit 1ns;
   timeprecision 1ps;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_type = prq_pkg::REQ_PUSH;
   logic [5:0] req_task_id = '0;
   logic [4:0] req_priority_req = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [5:0] rsp_next_task;
   logic       rsp_next_valid;
   logic [4:0] rsp_top_priority;
   logic [6:0] rsp_ready_count;
   logic       rsp_request_error;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [5:0] next_task;
      logic       next_valid;
      logic [4:0] top_priority;
      logic [6:0] ready_count;
      logic       request_error;
   } status_type;

   priority_ready_queue u_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the queue: one list per level, head at index 0
   int         level_list[prq_pkg::NUM_LEVELS][$];
   logic       queued[prq_pkg::NUM_TASKS];
   int         queued_level[prq_pkg::NUM_TASKS];
   int         queued_total;
   status_type status_fifo[$];
   int         errors = 0;
   int         sent = 0;
   int         received = 0;
   int         cycles = 0;
   bit         hold_off = 1'b0;
   bit         long_stall = 1'b0;

   // Apply one request to the shadow queue and return the expected status
   function automatic status_type predict_status(logic [1:0] kind, int tid, int lvl);
      status_type s;
      int         top;
      int         idx;
      s = '0;
      top = -1;
      for (int l = 0; l < prq_pkg::NUM_LEVELS; l++)
         if (top < 0 && level_list[l].size() > 0) top = l;
      case (kind)
         prq_pkg::REQ_PUSH: begin
            if (queued[tid]) s.request_error = 1'b1;
            else begin
               level_list[lvl].push_back(tid);
               queued[tid] = 1'b1;
               queued_level[tid] = lvl;
               queued_total++;
            end
         end
         prq_pkg::REQ_REMOVE: begin
            if (!queued[tid]) s.request_error = 1'b1;
            else begin
               idx = -1;
               foreach (level_list[queued_level[tid]][i])
                  if (level_list[queued_level[tid]][i] == tid) idx = i;
               level_list[queued_level[tid]].delete(idx);
               queued[tid] = 1'b0;
               queued_total--;
            end
         end
         prq_pkg::REQ_YIELD: begin
            if (top >= 0 && level_list[top][0] == tid) begin
               void'(level_list[top].pop_front());
               level_list[top].push_back(tid);
            end
         end
         default: ;
      endcase
      for (int l = prq_pkg::NUM_LEVELS - 1; l >= 0; l--)
         if (level_list[l].size() > 0) begin
            s.next_task = 6'(level_list[l][0]);
            s.next_valid = 1'b1;
            s.top_priority = 5'(l);
         end
      s.ready_count = 7'(queued_total);
      return s;
   endfunction

   // Offer one request, hold it until transferred, then optionally idle
   task automatic send_request(logic [1:0] kind, int tid, int lvl);
      req_valid <= 1'b1;
      req_type <= kind;
      req_task_id <= 6'(tid);
      req_priority_req <= 5'(lvl);
      do @(posedge clock); while (req_stall);
      status_fifo.push_back(predict_status(kind, tid, lvl));
      sent++;
      if (!hold_off && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 30) : $urandom_range(1, 3))
            @(posedge clock);
      end
   endtask

   task automatic drop_valid();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Receiver stall pattern
   always @(posedge clock) begin
      if (long_stall) rsp_stall <= 1'b1;
      else if (hold_off) rsp_stall <= 1'b0;
      else if ($urandom_range(0, 3) == 0) rsp_stall <= 1'b1;
      else rsp_stall <= 1'b0;
   end

   // Result checker
   always @(posedge clock) begin
      status_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_next_task, rsp_next_valid, rsp_top_priority,
                rsp_ready_count, rsp_request_error};
         received++;
         if (status_fifo.size() == 0) begin
            $display("%0t: unexpected status transfer %h", $time, got);
            errors++;
         end else begin
            want = status_fifo.pop_front();
            if (got.next_task !== want.next_task)
               $display("%0t: next_task exp %0d got %0d", $time, want.next_task, got.next_task);
            if (got.next_valid !== want.next_valid)
               $display("%0t: next_valid exp %0d got %0d", $time, want.next_valid,
                        got.next_valid);
            if (got.top_priority !== want.top_priority)
               $display("%0t: top_priority exp %0d got %0d", $time, want.top_priority,
                        got.top_priority);
            if (got.ready_count !== want.ready_count)
               $display("%0t: ready_count exp %0d got %0d", $time, want.ready_count,
                        got.ready_count);
            if (got.request_error !== want.request_error)
               $display("%0t: request_error exp %0d got %0d", $time, want.request_error,
                        got.request_error);
            if (got !== want) errors++;
         end
      end
   end

   // Cycle limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d left", cycles, status_fifo.size());
         $display("tb: failure");
         $finish;
      end
   end

   // Head of the current top level, or a random task when empty
   function automatic int top_head();
      for (int l = 0; l < prq_pkg::NUM_LEVELS; l++)
         if (level_list[l].size() > 0) return level_list[l][0];
      return $urandom_range(0, prq_pkg::NUM_TASKS - 1);
   endfunction

   function automatic int queued_task();
      int picks[$];
      for (int t = 0; t < prq_pkg::NUM_TASKS; t++) if (queued[t]) picks.push_back(t);
      if (picks.size() == 0) return $urandom_range(0, prq_pkg::NUM_TASKS - 1);
      return picks[$urandom_range(0, picks.size() - 1)];
   endfunction

   // Empty queue, extremes of ids and levels, errors and the unused code
   task automatic test_directed();
      send_request(prq_pkg::REQ_YIELD, 0, 0);
      send_request(prq_pkg::REQ_REMOVE, 5, 3);
      send_request(REQ_UNUSED, 63, 31);
      send_request(prq_pkg::REQ_PUSH, 63, 31);
      send_request(prq_pkg::REQ_PUSH, 0, 0);
      send_request(prq_pkg::REQ_PUSH, 0, 7);
      send_request(prq_pkg::REQ_PUSH, 42, 0);
      send_request(prq_pkg::REQ_PUSH, 21, 0);
      send_request(prq_pkg::REQ_YIELD, 42, 0);
      send_request(prq_pkg::REQ_YIELD, 0, 31);
      send_request(prq_pkg::REQ_REMOVE, 42, 31);
      send_request(prq_pkg::REQ_REMOVE, 0, 0);
      send_request(prq_pkg::REQ_YIELD, 21, 0);
      send_request(prq_pkg::REQ_REMOVE, 21, 0);
      send_request(prq_pkg::REQ_YIELD, 63, 0);
      send_request(prq_pkg::REQ_REMOVE, 63, 0);
      send_request(prq_pkg::REQ_REMOVE, 63, 0);
      send_request(REQ_UNUSED, 0, 0);
      drop_valid();
   endtask

   // Random mix of push, remove, yield and unused requests, mostly well-formed
   task automatic test_random(int count);
      int      r;
      int      tid;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < 40) begin
            tid = $urandom_range(0, prq_pkg::NUM_TASKS - 1);
            if (queued[tid] && $urandom_range(0, 3) != 0) tid = queued_task() ^ 1;
            send_request(prq_pkg::REQ_PUSH, tid,
                         $urandom_range(0, 3) == 0 ? $urandom_range(0, 31)
                                                  : $urandom_range(0, 3));
         end else if (r < 65)
            send_request(prq_pkg::REQ_REMOVE, $urandom_range(0, 7) == 0 ?
                         $urandom_range(0, 63) : queued_task(), $urandom_range(0, 31));
         else if (r < 95)
            send_request(prq_pkg::REQ_YIELD, $urandom_range(0, 4) == 0 ?
                         $urandom_range(0, 63) : top_head(), $urandom_range(0, 31));
         else
            send_request(REQ_UNUSED, $urandom_range(0, 63), $urandom_range(0, 31));
      end
      drop_valid();
   endtask

   // Receiver holds off for a long stretch while the sender keeps offering
   task automatic test_backpressure();
      hold_off = 1'b1;
      fork
         begin
            long_stall = 1'b1;
            repeat (200) @(posedge clock);
            long_stall = 1'b0;
         end
         for (int n = 0; n < 40; n++)
            send_request(prq_pkg::REQ_PUSH, $urandom_range(0, 63), $urandom_range(0, 31));
      join
      hold_off = 1'b0;
      drop_valid();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(600);
      test_backpressure();
      test_random(850);
      while (status_fifo.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("sent %0d requests (push, remove, yield, unused), %0d statuses checked",
               sent, received);
      $display("including a long receiver hold-off with the queue full of work");
      if (errors == 0 && status_fifo.size() == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end
endmodule
`default_nettype wire
